[src/text_console_cell_writer_unit_macros.svh]
// ============================================================================
// Text console cell writer assertion macros
// Shared concurrent-assertion shorthands for the console writer checker.
// ============================================================================
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TCCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console writer check failed");

// Next-cycle implication, disabled while reset is low.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console writer check failed");

`endif

[src/tccw_pkg.sv]
// ============================================================================
// Console writer package
// Command codes, queue entry type and glyph constants for the console writer.
// ============================================================================
package tccw_pkg;

    localparam int IDX_W = 11;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_PUT_AT = 2'd1;
    localparam logic [1:0] CMD_DEC    = 2'd2;
    localparam logic [1:0] CMD_HEX    = 2'd3;

    localparam logic [7:0] NEWLINE_CODE     = 8'h0A;
    localparam logic [7:0] GLYPH_ZERO       = 8'h30;
    localparam logic [7:0] GLYPH_X          = 8'h78;
    localparam logic [7:0] TEXT_COLOR_RESET = 8'h0F;

    localparam logic [3:0] HEX_LEN = 4'd10;

    // Reciprocal of ten: q = (x * RECIP10) >> RECIP_SHIFT is exact for 32-bit x.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] HEX_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [2:0] {
        KIND_PUT,
        KIND_NEWLINE,
        KIND_PUT_AT,
        KIND_DEC,
        KIND_HEX
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       glyph;
        logic [7:0]       color;
        logic [IDX_W-1:0] index;
        logic [31:0]      number;
    } entry_t;

endpackage

[src/tccw_front.sv]
// ============================================================================
// Console writer front end
// Accepts commands, classifies them and drops off-screen positioned writes.
// ============================================================================
module tccw_front #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             q_full,
    output logic             q_push,
    output tccw_pkg::entry_t q_entry
);
    import tccw_pkg::*;

    localparam logic [8:0]       WIDTH_C  = 9'(SCREEN_WIDTH);
    localparam logic [8:0]       HEIGHT_C = 9'(SCREEN_HEIGHT);
    localparam logic [IDX_W-1:0] WIDTH_I  = IDX_W'(SCREEN_WIDTH);

    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       on_screen;
    logic       keep;

    assign char_code  = s_tdata[7:0];
    assign cell_color = s_tdata[15:8];
    assign pos_x      = s_tdata[23:16];
    assign pos_y      = s_tdata[31:24];
    assign on_screen  = ({1'b0, pos_x} < WIDTH_C) && ({1'b0, pos_y} < HEIGHT_C);

    assign s_tready = !q_full;

    always_comb begin
        q_entry.glyph  = char_code;
        q_entry.color  = cell_color;
        q_entry.index  = IDX_W'(IDX_W'(pos_y) * WIDTH_I + IDX_W'(pos_x));
        q_entry.number = s_tdata[63:32];
        keep           = 1'b1;
        unique case (s_tuser)
            CMD_PUT: begin
                q_entry.kind = (char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_PUT;
            end
            CMD_PUT_AT: begin
                q_entry.kind = KIND_PUT_AT;
                keep         = on_screen;
            end
            CMD_DEC: begin
                q_entry.kind = KIND_DEC;
            end
            default: begin
                q_entry.kind = KIND_HEX;
            end
        endcase
    end

    // Drop off-screen positioned writes after the transfer.
    assign q_push = s_tvalid && s_tready && keep;

endmodule

[src/tccw_queue.sv]
// ============================================================================
// Console writer command queue
// Short FIFO of classified commands between the front and back ends.
// ============================================================================
module tccw_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tccw_pkg::entry_t push_entry,
    input  logic             pop,
    output tccw_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import tccw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_C);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/tccw_back.sv]
// ============================================================================
// Console writer back end
// Runs queued commands: cursor tracking, decimal and hex conversion and cell output.
// ============================================================================
module tccw_back #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       text_color,
    input  tccw_pkg::entry_t q_head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic             m_tlast
);
    import tccw_pkg::*;

    localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam logic [COL_W:0]     WIDTH_C  = (COL_W + 1)'(SCREEN_WIDTH);
    localparam logic [ROW_W:0]     HEIGHT_C = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic [IDX_W-1:0]   WIDTH_I  = IDX_W'(SCREEN_WIDTH);
    localparam int                 Q_W      = 64 - RECIP_SHIFT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_EMIT
    } state_t;

    state_t           state_reg,  state_next;
    kind_t            kind_reg,   kind_next;
    logic [7:0]       glyph_reg,  glyph_next;
    logic [7:0]       color_reg,  color_next;
    logic [IDX_W-1:0] index_reg,  index_next;
    logic [31:0]      num_reg,    num_next;
    logic [Q_W-1:0]   quot_reg,   quot_next;
    logic [3:0]       cnt_reg,    cnt_next;
    logic [ROW_W-1:0] row_reg,    row_next;
    logic [COL_W-1:0] col_reg,    col_next;
    logic             m_valid_reg, m_valid_next;
    logic [26:0]      m_data_reg,  m_data_next;
    logic             m_last_reg,  m_last_next;

    logic [3:0]       digit_store_reg [10];
    logic             digit_we;
    logic [3:0]       digit_val;

    logic [63:0]      product;
    logic [31:0]      quot_times_ten;
    logic [IDX_W-1:0] cursor_index;
    logic [ROW_W-1:0] row_wrap;
    logic [COL_W-1:0] col_step;
    logic [ROW_W-1:0] row_step;
    logic [7:0]       emit_glyph;
    logic             out_free;

    assign product        = num_reg * RECIP10;
    assign quot_times_ten = 32'({quot_reg, 3'b000}) + 32'({quot_reg, 1'b0});
    assign digit_val      = 4'(num_reg - quot_times_ten);
    assign cursor_index   = IDX_W'(IDX_W'(row_reg) * WIDTH_I + IDX_W'(col_reg));
    assign out_free       = !m_valid_reg || m_tready;

    // Next row with wrap to the top; no scrolling.
    assign row_wrap = ({1'b0, row_reg} + 1'b1 >= HEIGHT_C) ? '0 : row_reg + 1'b1;

    // Cursor after one glyph.
    always_comb begin
        if ({1'b0, col_reg} + 1'b1 >= WIDTH_C) begin
            col_step = '0;
            row_step = row_wrap;
        end else begin
            col_step = col_reg + 1'b1;
            row_step = row_reg;
        end
    end

    always_comb begin
        unique case (kind_reg)
            KIND_DEC: emit_glyph = GLYPH_ZERO + 8'(digit_store_reg[cnt_reg - 4'd1]);
            KIND_HEX: begin
                if (cnt_reg == HEX_LEN) begin
                    emit_glyph = GLYPH_ZERO;
                end else if (cnt_reg == HEX_LEN - 4'd1) begin
                    emit_glyph = GLYPH_X;
                end else begin
                    emit_glyph = HEX_GLYPHS[num_reg[31:28]];
                end
            end
            default: emit_glyph = glyph_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        glyph_next   = glyph_reg;
        color_next   = color_reg;
        index_next   = index_reg;
        num_next     = num_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        digit_we     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    kind_next  = q_head.kind;
                    glyph_next = q_head.glyph;
                    color_next = q_head.color;
                    index_next = q_head.index;
                    num_next   = q_head.number;
                    unique case (q_head.kind)
                        KIND_NEWLINE: begin
                            col_next = '0;
                            row_next = row_wrap;
                        end
                        KIND_DEC: begin
                            cnt_next   = 4'd0;
                            state_next = ST_MUL;
                        end
                        KIND_HEX: begin
                            cnt_next   = HEX_LEN;
                            state_next = ST_EMIT;
                        end
                        default: begin
                            cnt_next   = 4'd1;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                quot_next  = product[63:RECIP_SHIFT];
                state_next = ST_SUB;
            end
            ST_SUB: begin
                // Store the low digit, keep the quotient for the next pass.
                digit_we   = 1'b1;
                cnt_next   = cnt_reg + 4'd1;
                num_next   = 32'(quot_reg);
                state_next = (quot_reg == '0) ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = (cnt_reg == 4'd1);
                    if (kind_reg == KIND_PUT_AT) begin
                        m_data_next = {color_reg, glyph_reg, index_reg};
                    end else begin
                        m_data_next = {text_color, emit_glyph, cursor_index};
                        col_next    = col_step;
                        row_next    = row_step;
                    end
                    if (kind_reg == KIND_HEX && cnt_reg <= HEX_LEN - 4'd2) begin
                        num_next = {num_reg[27:0], 4'h0};
                    end
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (digit_we) begin
            digit_store_reg[cnt_reg] <= digit_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg   <= kind_next;
        glyph_reg  <= glyph_next;
        color_reg  <= color_next;
        index_reg  <= index_next;
        num_reg    <= num_next;
        quot_reg   <= quot_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

endmodule

[src/text_console_cell_writer_unit.sv]
// ============================================================================
// Text console cell writer
// Turns console commands into screen cell writes at a tracked cursor.
// ============================================================================
// Usage:
//   s_* carries one command per transfer: s_tuser is the command code
//   (put char, put char at position, write decimal, write hex), s_tdata holds
//   the character, colour, position and 32-bit number. m_* carries one cell
//   write per transfer; m_tlast marks the final write of a command.
//   cfg_wr_en/cfg_wr_data set the attribute used for cursor-based writes;
//   write it only while the block is idle.
// Command flow:
//   A command waits in a two-entry queue, then is dispatched once the previous
//   command has issued its last write. Put char: one write. Write hex: ten writes.
//   Write decimal: one write per digit for D digits (up to 10), produced by the
//   divide-by-ten loop, one reciprocal multiply and one subtract per digit.
//   Newline writes no cell; off-screen positioned writes are dropped at entry.
// Reset:
//   Cursor goes to row 0, column 0, attribute to 0x0F, queue and output empty.
// Stall:
//   A stalled m_tready holds the output; the queue still takes commands
//   until it fills, then s_tready drops.
// ============================================================================
module text_console_cell_writer_unit #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: text_color
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: char_code[7:0], cell_color[15:8], pos_x[23:16], pos_y[31:24],
    //        number[63:32]
    input  logic [63:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    // Cell write stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: cell_index[10:0], glyph[18:11], attribute[26:19], zero[31:27]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);
    import tccw_pkg::*;

    logic [7:0] text_color_reg;
    entry_t     push_entry;
    entry_t     head_entry;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;

    // Hold the attribute for cursor-based writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= TEXT_COLOR_RESET;
        end else if (cfg_wr_en) begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // Accept and classify commands.
    tccw_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    // Decouple intake from execution.
    tccw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(push_entry),
        .pop       (q_pop),
        .head      (head_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Execute commands and drive the cell write stream.
    tccw_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .text_color(text_color_reg),
        .q_head    (head_entry),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

[src/tccw_checker.sv]
// ============================================================================
// Console writer port checker
// Watches the top-level ports for output stability, range and run length.
// ============================================================================
`include "text_console_cell_writer_unit_macros.svh"

module tccw_checker #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    localparam int  CELLS      = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam bit  IDX_MASKED = (CELLS > 2048);

    logic [3:0] run_cnt_reg;
    logic       m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    // Count writes of the current command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_cnt_reg <= '0;
        end else if (m_xfer) begin
            run_cnt_reg <= m_tlast ? 4'd0 : run_cnt_reg + 4'd1;
        end
    end

    `TCCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    `TCCW_ASSERT_SAME(a_index_range, aclk, aresetn, m_tvalid,
        IDX_MASKED || (32'(m_tdata[10:0]) < CELLS))

    `TCCW_ASSERT_SAME(a_run_length, aclk, aresetn, m_xfer && !m_tlast, run_cnt_reg < 4'd9)

endmodule

bind text_console_cell_writer_unit tccw_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tccw_checker (.*);
